@@ rtl/rpnh_pkg.sv @@
package rpnh_pkg;

   // defaults for the top level parameters
   localparam int COORD_FRAC_BITS_DEF  = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   // field widths
   localparam int CW     = 32;  // coordinate
   localparam int DW     = 33;  // coordinate difference
   localparam int DIRW   = 18;  // ray direction
   localparam int PW     = 51;  // DW x DIRW product
   localparam int ACCW   = 68;  // product accumulator
   localparam int DENW   = 52;  // denominator and s numerator
   localparam int TNW    = 67;  // t numerator
   localparam int DISTW  = 31;  // hit distance
   localparam int NRMW   = 16;  // normal component
   localparam int RW     = 53;  // divider remainder
   localparam int QW     = 31;  // divider quotient
   localparam int ROOTW  = 34;  // square root
   localparam int SQREMW = 37;  // square root remainder
   localparam int CNTW   = 6;
   localparam int STEPW  = 4;
   localparam int LO_BITS = 17; // low part of a split 33 bit operand

   localparam int DIV_T_STEPS = 31;
   localparam int SQRT_STEPS  = ACCW / 2;

   localparam logic [DISTW-1:0] DIST_MAX = '1;

   // configuration register indexes
   localparam int CSR_IDXW = 3;
   localparam int CSR_DW   = 32;
   localparam logic [CSR_IDXW-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDXW-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDXW-1:0] CSR_DIR_X       = 3'd2;
   localparam logic [CSR_IDXW-1:0] CSR_DIR_Y       = 3'd3;
   localparam logic [CSR_IDXW-1:0] CSR_CLOSED_MODE = 3'd4;

   // multiplier operand selects
   localparam logic [1:0] A_EX = 2'd0;
   localparam logic [1:0] A_EY = 2'd1;
   localparam logic [1:0] A_RX = 2'd2;
   localparam logic [1:0] A_RY = 2'd3;

   localparam logic [2:0] B_DIRX = 3'd0;
   localparam logic [2:0] B_DIRY = 3'd1;
   localparam logic [2:0] B_EXLO = 3'd2;
   localparam logic [2:0] B_EXHI = 3'd3;
   localparam logic [2:0] B_EYLO = 3'd4;
   localparam logic [2:0] B_EYHI = 3'd5;

   // accumulator destinations
   localparam logic [1:0] SV_NONE = 2'd0;
   localparam logic [1:0] SV_DEN  = 2'd1;
   localparam logic [1:0] SV_SN   = 2'd2;
   localparam logic [1:0] SV_TN   = 2'd3;

   localparam logic [STEPW-1:0] MSTEP_TN_END    = 4'd7;
   localparam logic [STEPW-1:0] MSTEP_LEN_START = 4'd8;

   typedef struct packed {
      logic [1:0] a_sel;
      logic [2:0] b_sel;
      logic       hi;
      logic       neg;
      logic       clr;
      logic [1:0] save;
      logic       last;
   } mul_op_type;

   // multiply program: den, sn, tn, then squared segment length
   function automatic mul_op_type mul_op(input logic [STEPW-1:0] step);
      mul_op_type op;
      op = '{A_EX, B_DIRX, 1'b0, 1'b0, 1'b0, SV_NONE, 1'b0};
      case (step)
         4'd0:  op = '{A_EY, B_DIRX, 1'b0, 1'b0, 1'b1, SV_NONE, 1'b0};
         4'd1:  op = '{A_EX, B_DIRY, 1'b0, 1'b1, 1'b0, SV_DEN,  1'b0};
         4'd2:  op = '{A_RY, B_DIRX, 1'b0, 1'b0, 1'b1, SV_NONE, 1'b0};
         4'd3:  op = '{A_RX, B_DIRY, 1'b0, 1'b1, 1'b0, SV_SN,   1'b0};
         4'd4:  op = '{A_RY, B_EXLO, 1'b0, 1'b0, 1'b1, SV_NONE, 1'b0};
         4'd5:  op = '{A_RY, B_EXHI, 1'b1, 1'b0, 1'b0, SV_NONE, 1'b0};
         4'd6:  op = '{A_RX, B_EYLO, 1'b0, 1'b1, 1'b0, SV_NONE, 1'b0};
         4'd7:  op = '{A_RX, B_EYHI, 1'b1, 1'b1, 1'b0, SV_TN,   1'b1};
         4'd8:  op = '{A_EX, B_EXLO, 1'b0, 1'b0, 1'b1, SV_NONE, 1'b0};
         4'd9:  op = '{A_EX, B_EXHI, 1'b1, 1'b0, 1'b0, SV_NONE, 1'b0};
         4'd10: op = '{A_EY, B_EYLO, 1'b0, 1'b0, 1'b0, SV_NONE, 1'b0};
         4'd11: op = '{A_EY, B_EYHI, 1'b1, 1'b0, 1'b0, SV_NONE, 1'b1};
         default: op = '{A_EX, B_DIRX, 1'b0, 1'b0, 1'b0, SV_NONE, 1'b1};
      endcase
      return op;
   endfunction

   typedef struct packed {
      logic             accept;
      logic             first_load;
      logic             close_load;
      logic             diff_load;
      logic             mul;
      logic             acc;
      logic [STEPW-1:0] step;
      logic             norm;
      logic             test;
      logic             div_step;
      logic             upd;
      logic             sqrt_load;
      logic             sqrt_step;
      logic             nset;
      logic             nzero;
      logic             nst;
      logic             comp;
      logic             emit;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic reject;
      logic sat;
      logic better;
      logic len_zero;
      logic closed;
   } status_type;

endpackage

@@ rtl/rpnh_ctrl.sv @@
module rpnh_ctrl #(
   parameter int NORMAL_FRAC_BITS = rpnh_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_vertex,
   output logic                 req_stall,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output rpnh_pkg::cmd_type    cmd,
   input  rpnh_pkg::status_type sts
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLOSE = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_ACC   = 4'd4;
   localparam logic [3:0] S_NORM  = 4'd5;
   localparam logic [3:0] S_TEST  = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_UPD   = 4'd8;
   localparam logic [3:0] S_SQL   = 4'd9;
   localparam logic [3:0] S_SQRT  = 4'd10;
   localparam logic [3:0] S_NSET  = 4'd11;
   localparam logic [3:0] S_NDIV  = 4'd12;
   localparam logic [3:0] S_NST   = 4'd13;
   localparam logic [3:0] S_NEXT  = 4'd14;
   localparam logic [3:0] S_EMIT  = 4'd15;

   logic [3:0]                     state_ff, state_in;
   logic [rpnh_pkg::CNTW-1:0]      cnt_ff, cnt_in;
   logic [rpnh_pkg::STEPW-1:0]     step_ff, step_in;
   logic                           have_ff, have_in;
   logic                           last_ff, last_in;
   logic                           closing_ff, closing_in;
   logic                           comp_ff, comp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rpnh_pkg::mul_op_type           op;

   assign op        = rpnh_pkg::mul_op(step_ff);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      have_in      = have_ff;
      last_in      = last_ff;
      closing_in   = closing_ff;
      comp_in      = comp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      cmd.step     = step_ff;
      cmd.comp     = comp_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept     = 1'b1;
               cmd.first_load = !have_ff;
               have_in        = 1'b1;
               last_in        = req_last_vertex;
               closing_in     = 1'b0;
               state_in       = have_ff ? S_LOAD : S_NEXT;
            end
         end
         S_CLOSE: begin
            cmd.close_load = 1'b1;
            state_in       = S_LOAD;
         end
         S_LOAD: begin
            cmd.diff_load = 1'b1;
            step_in       = '0;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (op.last) begin
               state_in = (step_ff == rpnh_pkg::MSTEP_TN_END) ? S_NORM : S_SQL;
            end else begin
               step_in  = step_ff + rpnh_pkg::STEPW'(1);
               state_in = S_MUL;
            end
         end
         S_NORM: begin
            if (sts.den_zero) begin
               state_in = S_NEXT;
            end else begin
               cmd.norm = 1'b1;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (sts.reject) begin
               state_in = S_NEXT;
            end else begin
               cmd.test = 1'b1;
               cnt_in   = rpnh_pkg::CNTW'(rpnh_pkg::DIV_T_STEPS);
               state_in = sts.sat ? S_UPD : S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - rpnh_pkg::CNTW'(1);
            if (cnt_ff == rpnh_pkg::CNTW'(1)) state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            if (sts.better) begin
               step_in  = rpnh_pkg::MSTEP_LEN_START;
               state_in = S_MUL;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_SQL: begin
            cmd.sqrt_load = 1'b1;
            cnt_in        = rpnh_pkg::CNTW'(rpnh_pkg::SQRT_STEPS);
            comp_in       = 1'b0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff - rpnh_pkg::CNTW'(1);
            if (cnt_ff == rpnh_pkg::CNTW'(1)) state_in = S_NSET;
         end
         S_NSET: begin
            if (sts.len_zero) begin
               cmd.nzero = 1'b1;
               state_in  = S_NEXT;
            end else begin
               cmd.nset = 1'b1;
               cnt_in   = rpnh_pkg::CNTW'(NORMAL_FRAC_BITS);
               state_in = S_NDIV;
            end
         end
         S_NDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - rpnh_pkg::CNTW'(1);
            if (cnt_ff == rpnh_pkg::CNTW'(1)) state_in = S_NST;
         end
         S_NST: begin
            cmd.nst = 1'b1;
            if (!comp_ff) begin
               comp_in  = 1'b1;
               state_in = S_NSET;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (last_ff && !closing_ff && sts.closed) begin
               closing_in = 1'b1;
               state_in   = S_CLOSE;
            end else if (last_ff) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               have_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         have_ff      <= 1'b0;
         last_ff      <= 1'b0;
         closing_ff   <= 1'b0;
         comp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         have_ff      <= have_in;
         last_ff      <= last_in;
         closing_ff   <= closing_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/rpnh_datapath.sv @@
module rpnh_datapath #(
   parameter int COORD_FRAC_BITS = rpnh_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [rpnh_pkg::CW-1:0]       req_vertex_x,
   input  logic signed [rpnh_pkg::CW-1:0]       req_vertex_y,
   input  logic                                 csr_wr_en,
   input  logic [rpnh_pkg::CSR_IDXW-1:0]        csr_index,
   input  logic [rpnh_pkg::CSR_DW-1:0]          csr_wdata,
   output logic                                 rsp_hit,
   output logic [rpnh_pkg::DISTW-1:0]           rsp_hit_distance,
   output logic signed [rpnh_pkg::NRMW-1:0]     rsp_normal_x,
   output logic signed [rpnh_pkg::NRMW-1:0]     rsp_normal_y,
   input  rpnh_pkg::cmd_type                    cmd,
   output rpnh_pkg::status_type                 sts
);

   localparam int CW     = rpnh_pkg::CW;
   localparam int DW     = rpnh_pkg::DW;
   localparam int DIRW   = rpnh_pkg::DIRW;
   localparam int PW     = rpnh_pkg::PW;
   localparam int ACCW   = rpnh_pkg::ACCW;
   localparam int DENW   = rpnh_pkg::DENW;
   localparam int TNW    = rpnh_pkg::TNW;
   localparam int RW     = rpnh_pkg::RW;
   localparam int QW     = rpnh_pkg::QW;
   localparam int ROOTW  = rpnh_pkg::ROOTW;
   localparam int SQREMW = rpnh_pkg::SQREMW;
   localparam int NRMW   = rpnh_pkg::NRMW;
   localparam int LOB    = rpnh_pkg::LO_BITS;
   // t numerator after the fraction shift, and its part above the quotient bits
   localparam int NUMW   = TNW - 1 + COORD_FRAC_BITS;
   localparam int HIW    = NUMW - QW;
   localparam int CMPW   = (HIW > DENW) ? HIW : DENW;

   // configuration
   logic signed [CW-1:0]   origin_x_ff, origin_y_ff;
   logic signed [DIRW-1:0] dir_x_ff, dir_y_ff;
   logic                   closed_ff;

   // polyline and segment
   logic signed [CW-1:0] prev_x_ff, prev_y_ff, first_x_ff, first_y_ff;
   logic signed [CW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [DW-1:0] ex_ff, ey_ff, rx_ff, ry_ff;

   // multiply and accumulate
   rpnh_pkg::mul_op_type   op;
   logic signed [DW-1:0]   a_op;
   logic signed [DIRW-1:0] b_op;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [ACCW-1:0] acc_ff, acc_in, prod_ext, prod_sh;

   logic signed [DENW-1:0] den_ff, sn_ff, sn_n_ff;
   logic signed [TNW-1:0]  tn_ff, tn_n_ff;
   logic [DENW-1:0]        dabs_ff;

   // shared restoring divider
   logic [RW-1:0]   rem_ff, rem_shift, rem_sub;
   logic [DENW-1:0] dden_ff;
   logic [QW-1:0]   sh_ff, q_ff;
   logic            div_ge;

   logic [NUMW-1:0] num;
   logic [HIW-1:0]  num_hi;

   // square root
   logic [ACCW-1:0]   sq_rad_ff;
   logic [SQREMW-1:0] sq_rem_ff, sq_rem_shift, sq_trial;
   logic [ROOTW-1:0]  root_ff;
   logic              sq_ge;

   // normal component
   logic [DW-1:0]        nmag;
   logic                 nneg, nq0;
   logic [NRMW-1:0]      nval;

   // nearest hit
   logic                     any_hit_ff;
   logic [rpnh_pkg::DISTW-1:0] best_dist_ff;
   logic signed [NRMW-1:0]   best_nx_ff, best_ny_ff;

   assign op = rpnh_pkg::mul_op(cmd.step);

   always_comb begin
      case (op.a_sel)
         rpnh_pkg::A_EX: a_op = ex_ff;
         rpnh_pkg::A_EY: a_op = ey_ff;
         rpnh_pkg::A_RX: a_op = rx_ff;
         default:        a_op = ry_ff;
      endcase
      case (op.b_sel)
         rpnh_pkg::B_DIRX: b_op = dir_x_ff;
         rpnh_pkg::B_DIRY: b_op = dir_y_ff;
         rpnh_pkg::B_EXLO: b_op = {{(DIRW-LOB){1'b0}}, ex_ff[LOB-1:0]};
         rpnh_pkg::B_EXHI: b_op = {{(DIRW-(DW-LOB)){ex_ff[DW-1]}}, ex_ff[DW-1:LOB]};
         rpnh_pkg::B_EYLO: b_op = {{(DIRW-LOB){1'b0}}, ey_ff[LOB-1:0]};
         default:          b_op = {{(DIRW-(DW-LOB)){ey_ff[DW-1]}}, ey_ff[DW-1:LOB]};
      endcase
   end

   assign prod_in  = a_op * b_op;
   assign prod_ext = {{(ACCW-PW){prod_ff[PW-1]}}, prod_ff};
   assign prod_sh  = op.hi ? (prod_ext <<< LOB) : prod_ext;
   assign acc_in   = (op.clr ? '0 : acc_ff) + (op.neg ? -prod_sh : prod_sh);

   // t numerator scaled to the distance fraction
   assign num    = {tn_n_ff[TNW-2:0], {COORD_FRAC_BITS{1'b0}}};
   assign num_hi = num[NUMW-1:QW];

   assign rem_shift = {rem_ff[RW-2:0], sh_ff[QW-1]};
   assign div_ge    = (rem_shift >= RW'(dden_ff));
   assign rem_sub   = rem_shift - RW'(dden_ff);

   assign sq_rem_shift = {sq_rem_ff[SQREMW-3:0], sq_rad_ff[ACCW-1:ACCW-2]};
   assign sq_trial     = SQREMW'({root_ff, 2'b01});
   assign sq_ge        = (sq_rem_shift >= sq_trial);

   // x comes from -ey, y from ex
   assign nneg  = cmd.comp ? ex_ff[DW-1] : (ey_ff != '0) && !ey_ff[DW-1];
   assign nmag  = cmd.comp ? (ex_ff[DW-1] ? DW'(-ex_ff) : DW'(ex_ff))
                           : (ey_ff[DW-1] ? DW'(-ey_ff) : DW'(ey_ff));
   assign nq0   = (ROOTW'(nmag) >= root_ff);
   assign nval  = nneg ? -q_ff[NRMW-1:0] : q_ff[NRMW-1:0];

   assign sts.den_zero = (den_ff == '0);
   assign sts.reject   = sn_n_ff[DENW-1] || ($signed({1'b0, dabs_ff}) < sn_n_ff)
                         || tn_n_ff[TNW-1];
   assign sts.sat      = (CMPW'(num_hi) >= CMPW'(dabs_ff));
   assign sts.better   = !any_hit_ff || (q_ff < best_dist_ff);
   assign sts.len_zero = (root_ff == '0);
   assign sts.closed   = closed_ff;

   // control-visible state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         dir_x_ff     <= DIRW'(1 << COORD_FRAC_BITS);
         dir_y_ff     <= '0;
         closed_ff    <= 1'b0;
         any_hit_ff   <= 1'b0;
         best_dist_ff <= rpnh_pkg::DIST_MAX;
         best_nx_ff   <= '0;
         best_ny_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               rpnh_pkg::CSR_ORIGIN_X:    origin_x_ff <= csr_wdata[CW-1:0];
               rpnh_pkg::CSR_ORIGIN_Y:    origin_y_ff <= csr_wdata[CW-1:0];
               rpnh_pkg::CSR_DIR_X:       dir_x_ff    <= csr_wdata[DIRW-1:0];
               rpnh_pkg::CSR_DIR_Y:       dir_y_ff    <= csr_wdata[DIRW-1:0];
               rpnh_pkg::CSR_CLOSED_MODE: closed_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.upd) begin
            any_hit_ff <= 1'b1;
            if (sts.better) best_dist_ff <= q_ff;
         end
         if (cmd.nzero) begin
            best_nx_ff <= '0;
            best_ny_ff <= '0;
         end
         if (cmd.nst) begin
            if (cmd.comp) best_ny_ff <= nval;
            else          best_nx_ff <= nval;
         end
         if (cmd.emit) begin
            any_hit_ff   <= 1'b0;
            best_dist_ff <= rpnh_pkg::DIST_MAX;
            best_nx_ff   <= '0;
            best_ny_ff   <= '0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ax_ff     <= prev_x_ff;
         ay_ff     <= prev_y_ff;
         bx_ff     <= req_vertex_x;
         by_ff     <= req_vertex_y;
         prev_x_ff <= req_vertex_x;
         prev_y_ff <= req_vertex_y;
         if (cmd.first_load) begin
            first_x_ff <= req_vertex_x;
            first_y_ff <= req_vertex_y;
         end
      end
      if (cmd.close_load) begin
         ax_ff <= prev_x_ff;
         ay_ff <= prev_y_ff;
         bx_ff <= first_x_ff;
         by_ff <= first_y_ff;
      end
      if (cmd.diff_load) begin
         ex_ff <= DW'(bx_ff) - DW'(ax_ff);
         ey_ff <= DW'(by_ff) - DW'(ay_ff);
         rx_ff <= DW'(origin_x_ff) - DW'(ax_ff);
         ry_ff <= DW'(origin_y_ff) - DW'(ay_ff);
      end
      if (cmd.mul) prod_ff <= prod_in;
      if (cmd.acc) begin
         acc_ff <= acc_in;
         case (op.save)
            rpnh_pkg::SV_DEN: den_ff <= acc_in[DENW-1:0];
            rpnh_pkg::SV_SN:  sn_ff  <= acc_in[DENW-1:0];
            rpnh_pkg::SV_TN:  tn_ff  <= acc_in[TNW-1:0];
            default: ;
         endcase
      end
      // make the denominator positive, negating sn and tn with it
      if (cmd.norm) begin
         dabs_ff <= den_ff[DENW-1] ? DENW'(-den_ff) : DENW'(den_ff);
         sn_n_ff <= den_ff[DENW-1] ? -sn_ff : sn_ff;
         tn_n_ff <= den_ff[DENW-1] ? -tn_ff : tn_ff;
      end
      if (cmd.test) begin
         if (sts.sat) begin
            q_ff <= rpnh_pkg::DIST_MAX;
         end else begin
            q_ff    <= '0;
            rem_ff  <= RW'(num_hi);
            sh_ff   <= num[QW-1:0];
            dden_ff <= dabs_ff;
         end
      end
      if (cmd.nset) begin
         q_ff    <= QW'(nq0);
         rem_ff  <= RW'(ROOTW'(nmag) - (nq0 ? root_ff : '0));
         sh_ff   <= '0;
         dden_ff <= DENW'(root_ff);
      end
      if (cmd.div_step) begin
         rem_ff <= div_ge ? rem_sub : rem_shift;
         q_ff   <= {q_ff[QW-2:0], div_ge};
         sh_ff  <= {sh_ff[QW-2:0], 1'b0};
      end
      if (cmd.sqrt_load) begin
         sq_rad_ff <= acc_ff;
         sq_rem_ff <= '0;
         root_ff   <= '0;
      end
      if (cmd.sqrt_step) begin
         sq_rad_ff <= {sq_rad_ff[ACCW-3:0], 2'b00};
         sq_rem_ff <= sq_ge ? (sq_rem_shift - sq_trial) : sq_rem_shift;
         root_ff   <= {root_ff[ROOTW-2:0], sq_ge};
      end
      if (cmd.emit) begin
         rsp_hit          <= any_hit_ff;
         rsp_hit_distance <= best_dist_ff;
         rsp_normal_x     <= best_nx_ff;
         rsp_normal_y     <= best_ny_ff;
      end
   end

endmodule

@@ rtl/ray_polyline_nearest_hit_core.sv @@
// Nearest hit of a fixed 2D ray on a polyline. Vertices arrive one word at a time
// (Q16.16 by default); each vertex after the first closes a segment, and with
// closed_mode set the final vertex also closes back to the first one. On the
// word marked last_vertex one result word is produced: hit flag, nearest ray
// parameter (all ones when nothing is hit or the distance overflows) and the
// unit normal of that segment in Q2.14. Ties keep the earlier segment.
// The block works on one vertex at a time. It is built around one shared 33x18
// multiplier (up to 12 partial products per segment), one restoring divider that
// makes a quotient bit per cycle (31 bits for the distance, NORMAL_FRAC_BITS+1
// per normal component) and a square root unit making one root bit per cycle
// (34 bits). The closing segment adds its own cost to the last word, and the
// last word also loads the result register. A finished result sits in an output
// register; the next polyline may start while it waits. Configuration is
// written through csr_wr_en/csr_index/csr_wdata; the user must write it only
// while idle, which the block itself does not enforce.
module ray_polyline_nearest_hit_core #(
   parameter int COORD_FRAC_BITS  = rpnh_pkg::COORD_FRAC_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = rpnh_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // vertex words
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [rpnh_pkg::CW-1:0]       req_vertex_x,
   input  logic signed [rpnh_pkg::CW-1:0]       req_vertex_y,
   input  logic                                 req_last_vertex,
   // result words
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [rpnh_pkg::DISTW-1:0]           rsp_hit_distance,
   output logic signed [rpnh_pkg::NRMW-1:0]     rsp_normal_x,
   output logic signed [rpnh_pkg::NRMW-1:0]     rsp_normal_y,
   // register writes
   input  logic                                 csr_wr_en,
   input  logic [rpnh_pkg::CSR_IDXW-1:0]        csr_index,
   input  logic [rpnh_pkg::CSR_DW-1:0]          csr_wdata
);

   rpnh_pkg::cmd_type    cmd;
   rpnh_pkg::status_type sts;

   // sequencing: segment setup, multiply program, divide, root, normal
   rpnh_ctrl #(
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_vertex (req_last_vertex),
      .req_stall       (req_stall),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .cmd             (cmd),
      .sts             (sts)
   );

   // arithmetic, polyline state and result register
   rpnh_datapath #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_hit          (rsp_hit),
      .rsp_hit_distance (rsp_hit_distance),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

@@ rtl/rpnh_checker.sv @@
module rpnh_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_hit,
   input logic [rpnh_pkg::DISTW-1:0]           rsp_hit_distance,
   input logic signed [rpnh_pkg::NRMW-1:0]     rsp_normal_x,
   input logic signed [rpnh_pkg::NRMW-1:0]     rsp_normal_y
);

   // no result right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word after reset");

   // a held result word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit)
      && $stable(rsp_hit_distance) && $stable(rsp_normal_x) && $stable(rsp_normal_y))
      else $error("stalled result word changed");

   // a miss reports the saturated distance and a zero normal
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_distance == rpnh_pkg::DIST_MAX
      && rsp_normal_x == '0 && rsp_normal_y == '0)
      else $error("miss with distance or normal set");

   // a result word does not rise in the cycle after a vertex is accepted
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result word in the cycle after a vertex");

endmodule

bind ray_polyline_nearest_hit_core rpnh_checker u_rpnh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hit          (rsp_hit),
   .rsp_hit_distance (rsp_hit_distance),
   .rsp_normal_x     (rsp_normal_x),
   .rsp_normal_y     (rsp_normal_y)
);

@@ verif/tb_ray_polyline_nearest_hit_core.sv @@
module tb_ray_polyline_nearest_hit_core;
   import rpnh_pkg::*;

   localparam int NFRAC      = NORMAL_FRAC_BITS_DEF;
   localparam int CFRAC      = COORD_FRAC_BITS_DEF;
   localparam int DRAIN_WAIT = 400;      // worst word with a closing segment, with margin
   localparam int CYCLE_CAP  = 1000000;
   localparam logic signed [CW-1:0] ONE = 32'sd1 <<< CFRAC;

   typedef logic signed [127:0] wide_s_type;
   typedef logic [127:0]        wide_u_type;

   typedef struct {
      logic             hit;
      logic [DISTW-1:0] distance;
      logic [NRMW-1:0]  nx;
      logic [NRMW-1:0]  ny;
   } hit_word_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [CW-1:0] req_vertex_x;
   logic signed [CW-1:0] req_vertex_y;
   logic                 req_last_vertex;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_hit;
   logic [DISTW-1:0]     rsp_hit_distance;
   logic signed [NRMW-1:0] rsp_normal_x;
   logic signed [NRMW-1:0] rsp_normal_y;
   logic                 csr_wr_en;
   logic [CSR_IDXW-1:0]  csr_index;
   logic [CSR_DW-1:0]    csr_wdata;

   ray_polyline_nearest_hit_core dut (.*);

   // predictor copy of the registers
   logic signed [CW-1:0]   ray_ox, ray_oy;
   logic signed [DIRW-1:0] ray_dx, ray_dy;
   logic                   ray_closed;
   // predictor copy of the polyline state
   logic signed [CW-1:0]   poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
   logic                   poly_started, poly_any_hit;
   logic [DISTW-1:0]       poly_best_dist;
   logic [NRMW-1:0]        poly_best_nx, poly_best_ny;

   hit_word_type hits_pending[$];
   int        mismatches;
   int        cycles;
   int        burst_left;

   // clock, and a cap on the run length
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic wide_u_type isqrt_of(input wide_u_type v);
      wide_u_type r, c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (wide_u_type'(1) << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   // truncated toward zero, then wrapped to the component width
   function automatic logic [NRMW-1:0] unit_comp(input wide_s_type c, input wide_u_type len);
      wide_u_type mag_c, q;
      mag_c = (c < 0) ? wide_u_type'(-c) : wide_u_type'(c);
      q = (mag_c << NFRAC) / len;
      return (c < 0) ? NRMW'(-q) : NRMW'(q);
   endfunction

   function automatic void intersect_segment(input logic signed [CW-1:0] ax,
                                             input logic signed [CW-1:0] ay,
                                             input logic signed [CW-1:0] bx,
                                             input logic signed [CW-1:0] by);
      wide_s_type ex, ey, rx, ry, dxw, dyw, den, sn, tn, ux, uy;
      wide_u_type num, q, len;
      logic [DISTW-1:0] t;
      ex = wide_s_type'(bx) - wide_s_type'(ax);
      ey = wide_s_type'(by) - wide_s_type'(ay);
      rx = wide_s_type'(ray_ox) - wide_s_type'(ax);
      ry = wide_s_type'(ray_oy) - wide_s_type'(ay);
      dxw = wide_s_type'(ray_dx);
      dyw = wide_s_type'(ray_dy);
      den = dxw * ey - dyw * ex;
      sn  = ry * dxw - rx * dyw;
      tn  = ry * ex - rx * ey;
      if (den == 0) return;          // parallel or degenerate
      if (den < 0) begin
         den = -den;
         sn  = -sn;
         tn  = -tn;
      end
      if (sn < 0 || sn > den || tn < 0) return;
      num = wide_u_type'(tn) << CFRAC;
      q = num / wide_u_type'(den);
      t = (q > wide_u_type'(DIST_MAX)) ? DIST_MAX : DISTW'(q);
      if (!poly_any_hit || t < poly_best_dist) begin
         ux = wide_s_type'(ax) - wide_s_type'(bx);
         uy = wide_s_type'(ay) - wide_s_type'(by);
         len = isqrt_of(wide_u_type'(ux * ux) + wide_u_type'(uy * uy));
         if (len == 0) begin
            poly_best_nx = '0;
            poly_best_ny = '0;
         end else begin
            poly_best_nx = unit_comp(uy, len);
            poly_best_ny = unit_comp(-ux, len);
         end
         poly_best_dist = t;
      end
      poly_any_hit = 1'b1;
   endfunction

   function automatic void clear_polyline();
      poly_first_x = '0;
      poly_first_y = '0;
      poly_prev_x = '0;
      poly_prev_y = '0;
      poly_started = 1'b0;
      poly_any_hit = 1'b0;
      poly_best_dist = DIST_MAX;
      poly_best_nx = '0;
      poly_best_ny = '0;
   endfunction

   function automatic void predict_vertex(input logic signed [CW-1:0] vx,
                                          input logic signed [CW-1:0] vy,
                                          input logic last);
      hit_word_type w;
      if (!poly_started) begin
         poly_first_x = vx;
         poly_first_y = vy;
         poly_started = 1'b1;
      end else begin
         intersect_segment(poly_prev_x, poly_prev_y, vx, vy);
      end
      poly_prev_x = vx;
      poly_prev_y = vy;
      if (!last) return;
      if (ray_closed) intersect_segment(vx, vy, poly_first_x, poly_first_y);
      w.hit      = poly_any_hit;
      w.distance = poly_best_dist;
      w.nx       = poly_any_hit ? poly_best_nx : '0;
      w.ny       = poly_any_hit ? poly_best_ny : '0;
      hits_pending.push_back(w);
      clear_polyline();
   endfunction

   // ---------------------------------------------------------------- drivers

   // lower valid when the sender goes quiet
   task automatic quiet_req();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      burst_left = 0;
   endtask

   // one vertex word; valid stays high inside a burst
   task automatic send_vertex(input logic signed [CW-1:0] vx,
                              input logic signed [CW-1:0] vy,
                              input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      req_valid       <= 1'b1;
      req_vertex_x    <= vx;
      req_vertex_y    <= vy;
      req_last_vertex <= last;
      do @(posedge clock); while (req_stall);
      predict_vertex(vx, vy, last);
      burst_left--;
   endtask

   task automatic wait_all_hits();
      quiet_req();
      while (hits_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // all registers plus an index past the list, which must be ignored
   task automatic set_ray(input logic signed [CW-1:0] ox, input logic signed [CW-1:0] oy,
                          input logic signed [DIRW-1:0] dx, input logic signed [DIRW-1:0] dy,
                          input logic closed);
      logic [CSR_DW-1:0] vals[6];
      logic [CSR_IDXW-1:0] idx[6];
      idx  = '{CSR_ORIGIN_X, CSR_ORIGIN_Y, CSR_DIR_X, CSR_DIR_Y, CSR_CLOSED_MODE,
               CSR_CLOSED_MODE + 3'd1};
      vals = '{ox, oy, CSR_DW'(dx), CSR_DW'(dy), CSR_DW'(closed), $urandom()};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
      ray_ox = ox;
      ray_oy = oy;
      ray_dx = dx;
      ray_dy = dy;
      ray_closed = closed;
   endtask

   // ---------------------------------------------------------------- checking

   // receiver stall pattern: mode changes every so often
   int stall_mode, stall_hold;
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_hold <= $urandom_range(20, 200);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   always @(posedge clock) begin
      hit_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hits_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word hit=%0d dist=%h",
                                           rsp_hit, rsp_hit_distance);
         end else begin
            w = hits_pending.pop_front();
            if (w.hit !== rsp_hit || w.distance !== rsp_hit_distance ||
                w.nx !== rsp_normal_x || w.ny !== rsp_normal_y) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: exp hit=%0d dist=%h n=(%h,%h)",
                            " got hit=%0d dist=%h n=(%h,%h)"},
                           w.hit, w.distance, w.nx, w.ny,
                           rsp_hit, rsp_hit_distance, rsp_normal_x, rsp_normal_y);
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // ray along +x from the origin: misses, hits, ties, parallel and far segments
   task automatic test_open_polylines();
      set_ray(0, 0, 18'sd65536, 0, 1'b0);
      send_vertex(0, 0, 1'b1);                                // single vertex
      send_vertex(10 * ONE, -ONE, 1'b0);
      send_vertex(10 * ONE, ONE, 1'b1);                       // plain hit
      send_vertex(0, ONE, 1'b0);
      send_vertex(5 * ONE, ONE, 1'b1);                        // parallel
      send_vertex(5 * ONE, -ONE, 1'b0);
      send_vertex(5 * ONE, ONE, 1'b0);
      send_vertex(5 * ONE, -ONE, 1'b0);                       // tie, earlier kept
      send_vertex(3 * ONE, 2 * ONE, 1'b1);                    // then nearer
      send_vertex(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
      send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1);        // field extremes
      send_vertex(-4 * ONE, -ONE, 1'b0);
      send_vertex(-4 * ONE, ONE, 1'b1);                       // behind the origin
      wait_all_hits();
   endtask

   // closing segment, degenerate closing, tiny direction for saturation
   task automatic test_closed_and_far();
      set_ray(32'sh80000000, 32'sh7FFFFFFF, 0, -18'sd65536, 1'b1);
      send_vertex(32'sh80000000, 0, 1'b1);                    // closes on itself
      send_vertex(-ONE, 0, 1'b0);
      send_vertex(ONE, 0, 1'b0);
      send_vertex(0, 32'sh80000000, 1'b1);
      wait_all_hits();
      set_ray(0, 0, 18'sd1, 0, 1'b1);
      send_vertex(30000 * ONE, -ONE, 1'b0);
      send_vertex(30000 * ONE, ONE, 1'b0);
      send_vertex(ONE, 3 * ONE, 1'b1);
      send_vertex(ONE, 0, 1'b0);
      send_vertex(ONE, ONE, 1'b1);                            // ends exactly on the ray
      wait_all_hits();
   endtask

   function automatic logic signed [CW-1:0] pick_coord(input logic signed [CW-1:0] centre);
      case ($urandom_range(0, 9))
         0, 1: return $urandom();
         2: return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
         3, 4, 5: return centre + ($signed($urandom_range(0, 40)) - 20) * ONE;
         default: return centre + $signed($urandom_range(0, 40 * ONE)) - 20 * ONE;
      endcase
   endfunction

   task automatic test_random_polylines(input int phases, input int words_per_phase);
      logic signed [CW-1:0]   ox, oy, cx, cy;
      logic signed [DIRW-1:0] dx, dy;
      int len, sent;
      for (int p = 0; p < phases; p++) begin
         ox = ($urandom_range(0, 3) == 0) ? $urandom() : pick_coord(0);
         oy = ($urandom_range(0, 3) == 0) ? $urandom() : pick_coord(0);
         case ($urandom_range(0, 4))
            0: begin dx = 18'sd65536; dy = 0; end
            1: begin dx = 0; dy = -18'sd65536; end
            2: begin dx = 18'sd46341; dy = -18'sd46341; end
            3: begin dx = -18'sd65536; dy = 18'sd1; end
            default: begin
               dx = DIRW'($signed($urandom_range(0, 131072)) - 65536);
               dy = DIRW'($signed($urandom_range(0, 131072)) - 65536);
            end
         endcase
         set_ray(ox, oy, dx, dy, (p % 2) == 1);
         // vertices scattered around a point ahead of the ray
         cx = ox + dx * 8;
         cy = oy + dy * 8;
         sent = 0;
         while (sent < words_per_phase) begin
            len = $urandom_range(1, 6);
            for (int v = 0; v < len; v++)
               send_vertex(pick_coord(cx), pick_coord(cy), v == len - 1);
            sent += len;
         end
         // sender holds off until every result has come
         wait_all_hits();
      end
   endtask

   // ---------------------------------------------------------------- main

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_vertex_x = '0;
      req_vertex_y = '0;
      req_last_vertex = 1'b0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      cycles = 0;
      burst_left = 0;
      stall_mode = 0;
      stall_hold = 0;
      ray_ox = 0;
      ray_oy = 0;
      ray_dx = 18'sd65536;
      ray_dy = 0;
      ray_closed = 1'b0;
      clear_polyline();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_open_polylines();
      test_closed_and_far();
      test_random_polylines(8, 80);

      wait_all_hits();
      if (mismatches == 0 && hits_pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
